// ===== sv/ps2mct_pkg.sv =====
// Package for the PS/2 wheel-mouse packet cursor tracker.
// Holds the packet bit positions, register indexes, reset sizes and the packet phase type.
// No dependencies.
`default_nettype none

package ps2mct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 1;

  // head byte layout
  localparam int SYNC_POS  = 3;
  localparam int XSIGN_POS = 4;
  localparam int YSIGN_POS = 5;
  localparam int BTN_W     = 3;
  localparam int WHEEL_W   = 4;
  localparam int MOVE_W    = 9;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic ACT_RAW   = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_XLOW  = 2'd1,
    PH_YLOW  = 2'd2,
    PH_WHEEL = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ===== sv/ps2_mouse_packet_cursor_tracker.sv =====
// Requests pass the input register, then the result register; one request per cycle
// is taken while no result is blocked; bytes that end no packet produce no result.
// The decode, cursor add and clamp sit between the input register and the result register.
// Reset (synchronous, rst_n low): packet phase to head byte, buttons 0, cursor at half of
// the reset screen size (1024 x 768), clamped to the coordinate range; no clearing pass.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF,
  localparam int OUT_W     = 2 * COORD_BITS + 25,
  localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // in_tdata: rx_byte[7:0], event_status[15:8], event_dx[23:16], event_dy[31:24]
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [31:0]                          in_tdata,
  // in_tuser: action[0], from_aux[1]
  input  wire  [1:0]                           in_tuser,
  // out_tdata: cursor_x, cursor_y, button_bits[3], move_x[9], move_y[9], wheel[4], zero pad
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [OUT_TW-1:0]                    out_tdata,
  input  wire                                  cfg_we,
  input  wire  [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ps2mct_pkg::CFG_W-1:0]         cfg_wdata
);

  import ps2mct_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SW = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;
  localparam logic [SW-1:0] LIMIT_EXT = SW'(1) << CB;
  localparam logic [SW-1:0] MASK_EXT  = LIMIT_EXT - SW'(1);
  localparam logic [SW-1:0] XR_EXT    = SW'(WIDTH_RESET >> 1);
  localparam logic [SW-1:0] YR_EXT    = SW'(HEIGHT_RESET >> 1);
  localparam logic [CB-1:0] POS_X_RST = (XR_EXT > MASK_EXT) ? MASK_EXT[CB-1:0] : XR_EXT[CB-1:0];
  localparam logic [CB-1:0] POS_Y_RST = (YR_EXT > MASK_EXT) ? MASK_EXT[CB-1:0] : YR_EXT[CB-1:0];

  // configuration
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_r;
  logic        act_r, aux_r;
  logic [7:0]  rx_r, ev_status_r, ev_dx_r, ev_dy_r;
  logic        adv;

  assign adv       = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rx_r        <= in_tdata[7:0];
      ev_status_r <= in_tdata[15:8];
      ev_dx_r     <= in_tdata[23:16];
      ev_dy_r     <= in_tdata[31:24];
      act_r       <= in_tuser[0];
      aux_r       <= in_tuser[1];
    end
  end

  // packet state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       head_r, x_low_r, y_low_r;
  logic [BTN_W-1:0] btn_r;
  logic [CB-1:0]    pos_x_r, pos_y_r;

  logic             raw_take;
  assign raw_take = adv && (act_r == ACT_RAW) && aux_r;

  always_comb begin
    phase_nxt = phase_r;
    if (raw_take) begin
      case (phase_r)
        PH_HEAD:  phase_nxt = rx_r[SYNC_POS] ? PH_XLOW : PH_HEAD;
        PH_XLOW:  phase_nxt = PH_YLOW;
        PH_YLOW:  phase_nxt = PH_WHEEL;
        PH_WHEEL: phase_nxt = PH_HEAD;
        default:  phase_nxt = PH_HEAD;
      endcase
    end
  end

  // result selection
  logic               emit;
  logic [7:0]         sel_status, sel_dx, sel_dy;
  logic [WHEEL_W-1:0] sel_wheel;
  logic [BTN_W-1:0]   sel_btn;

  always_comb begin
    emit       = 1'b0;
    sel_status = ev_status_r;
    sel_dx     = ev_dx_r;
    sel_dy     = ev_dy_r;
    sel_wheel  = '0;
    sel_btn    = btn_r;
    if (adv) begin
      if (act_r == ACT_EVENT) begin
        emit = 1'b1;
      end else if (aux_r && phase_r == PH_WHEEL) begin
        emit       = 1'b1;
        sel_status = head_r;
        sel_dx     = x_low_r;
        sel_dy     = y_low_r;
        sel_wheel  = rx_r[WHEEL_W-1:0];
        sel_btn    = head_r[BTN_W-1:0];
      end
    end
  end

  // screen limits: zero acts as one, oversize acts as the full coordinate range
  logic [CB-1:0] top_x, top_y;
  logic [SW-1:0] w_ext, h_ext, w_m1, h_m1;

  always_comb begin
    w_ext = SW'(width_r);
    h_ext = SW'(height_r);
    w_m1  = w_ext - SW'(1);
    h_m1  = h_ext - SW'(1);
    if (w_ext == '0)            top_x = '0;
    else if (w_ext > LIMIT_EXT) top_x = '1;
    else                        top_x = w_m1[CB-1:0];
    if (h_ext == '0)            top_y = '0;
    else if (h_ext > LIMIT_EXT) top_y = '1;
    else                        top_y = h_m1[CB-1:0];
  end

  // cursor move and clamp
  logic signed [MOVE_W-1:0] mx, my;
  logic signed [CB+1:0]     sx, sy;
  logic [CB-1:0]            new_x, new_y;

  always_comb begin
    mx = $signed({sel_status[XSIGN_POS], sel_dx});
    my = $signed({sel_status[YSIGN_POS], sel_dy});
    sx = $signed({2'b00, pos_x_r}) + $signed({{(CB - 7){mx[MOVE_W-1]}}, mx});
    sy = $signed({2'b00, pos_y_r}) - $signed({{(CB - 7){my[MOVE_W-1]}}, my});
    if (sx[CB+1])                    new_x = '0;
    else if (sx[CB:0] > {1'b0, top_x}) new_x = top_x;
    else                             new_x = sx[CB-1:0];
    if (sy[CB+1])                    new_y = '0;
    else if (sy[CB:0] > {1'b0, top_y}) new_y = top_y;
    else                             new_y = sy[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      head_r  <= '0;
      x_low_r <= '0;
      y_low_r <= '0;
      btn_r   <= '0;
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
    end else begin
      phase_r <= phase_nxt;
      if (raw_take) begin
        case (phase_r)
          PH_HEAD:  if (rx_r[SYNC_POS]) head_r <= rx_r;
          PH_XLOW:  x_low_r <= rx_r;
          PH_YLOW:  y_low_r <= rx_r;
          default:  ;
        endcase
      end
      if (emit) begin
        btn_r   <= sel_btn;
        pos_x_r <= new_x;
        pos_y_r <= new_y;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata <= OUT_TW'({sel_wheel, my, mx, sel_btn, new_y, new_x});
    end
  end

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(emit))
    else $error("result appeared without a processed request");

  a_event_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && act_r == ACT_EVENT) |=> (out_tvalid && out_tdata[OUT_W-1 -: WHEEL_W] == '0))
    else $error("direct event result carries a wheel count");

  a_packet_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (raw_take && phase_r == PH_WHEEL) |=> (phase_r == PH_HEAD && out_tvalid))
    else $error("fourth byte did not close the packet");

  a_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && act_r == ACT_EVENT) |=> $stable(phase_r))
    else $error("direct event disturbed packet phase");

endmodule

`default_nettype wire
